// ===== hdl/ipcd_pkg.sv =====
`timescale 1ns / 1ps
package ipcd_pkg;

  localparam int unsigned MaxBaud  = 16;
  localparam int unsigned IdxW     = $clog2(MaxBaud);
  localparam int unsigned FillW    = IdxW + 1;
  localparam int unsigned SampW    = 64;
  localparam int unsigned QDepth   = 2;
  // Magnitude width of a correlation sum and the divider step count.
  localparam int unsigned DivW     = 20;
  localparam int unsigned DivSteps = 20;

  // Configuration register indexes.
  localparam logic [0:0] RegCodeLength = 1'b0;
  localparam logic [0:0] RegCodeSigns  = 1'b1;

  typedef struct packed {
    logic        last_in;
    logic [15:0] back_q;
    logic [15:0] back_i;
    logic [15:0] main_q;
    logic [15:0] main_i;
  } in_item_t;

  typedef struct packed {
    logic        last_out;
    logic        is_decoded;
    logic [15:0] out_back_q;
    logic [15:0] out_back_i;
    logic [15:0] out_main_q;
    logic [15:0] out_main_i;
  } out_item_t;

  // One classified sample between the front and back parts.
  typedef struct packed {
    logic [SampW-1:0] samp;
    logic             last;
  } cmd_t;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRead  = 5'b00010,
    StAcc   = 5'b00100,
    StDiv   = 5'b01000,
    StEmit  = 5'b10000
  } back_state_e;

endpackage

// ===== hdl/ipcd_ram.sv =====
`timescale 1ns / 1ps
module ipcd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/ipcd_front.sv =====
`timescale 1ns / 1ps
module ipcd_front import ipcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);
  cmd_t                    buf_q [QDepth];
  logic [$clog2(QDepth):0] cnt_q, cnt_d;
  logic [$clog2(QDepth)-1:0] wp_q, rp_q;
  logic                    wr, rd;
  logic [15:0]             neg_i, neg_q;

  assign full        = (cnt_q == ($clog2(QDepth)+1)'(QDepth));
  assign wr          = push && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign rd          = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = buf_q[rp_q];

  // Main pair is inverted with 16-bit wrap before it is queued.
  assign neg_i = 16'(-item_i.main_i);
  assign neg_q = 16'(-item_i.main_q);

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) cnt_d = cnt_q + 1'b1;
    else if (!wr && rd) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= '0;
      rp_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
    end
  end

  // Queue payload.
  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wp_q] <= '{samp: {item_i.back_q, item_i.back_i, neg_q, neg_i},
                       last: item_i.last_in};
    end
  end
endmodule

// ===== hdl/ipcd_back.sv =====
`timescale 1ns / 1ps
module ipcd_back import ipcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [4:0]  code_length_i,
  input  logic [15:0] code_signs_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   res_o
);
  back_state_e        state_q, state_d;
  logic [FillW-1:0]   fill_q, len;
  logic [FillW:0]     len_ext;
  logic [IdxW-1:0]    head_q, tap_q, raddr, waddr;
  logic               last_q, dec_q, ov_q, ov_d;
  logic [SampW-1:0]   rdata;
  logic signed [20:0] acc_q [4];
  logic [DivW-1:0]    num_q [4];
  logic [5:0]         rem_q [4];
  logic               sgn_q [4];
  logic [5:0]         trial [4];
  logic               fit [4];
  logic [15:0]        raw_q [4];
  logic [15:0]        res_val [4];
  logic [4:0]         dstep_q;
  logic               ram_we, tap_last, plus, dec_go, drain_go;
  out_item_t          res_q;

  // Effective length, zero acts as one, clamped to the window depth.
  always_comb begin
    if (code_length_i == '0) len = FillW'(1);
    else if (code_length_i > 5'(MaxBaud)) len = FillW'(MaxBaud);
    else len = FillW'(code_length_i);
  end

  assign len_ext     = {1'b0, len};
  assign cmd_ready_o = (state_q == StIdle);
  assign ram_we      = cmd_valid_i && cmd_ready_o;
  assign waddr       = head_q + fill_q[IdxW-1:0];
  // The read port runs one tap ahead of the accumulator.
  assign raddr       = (state_q == StAcc) ? head_q + tap_q + IdxW'(1) : head_q;
  assign empty       = !ov_q;
  assign res_o       = res_q;
  assign tap_last    = ({1'b0, tap_q} == len - FillW'(1));
  assign plus        = code_signs_i[tap_q];
  assign dec_go      = (fill_q >= len);
  assign drain_go    = last_q && (fill_q != '0);

  ipcd_ram #(.Width(SampW), .Depth(MaxBaud)) u_win (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.samp),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer: store sample, then emit while the window is full or draining.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (ram_we) state_d = StRead;
      StRead:  state_d = (dec_go || drain_go) ? StAcc : StIdle;
      StAcc:   begin
        if (!dec_q || tap_last) state_d = dec_q ? StDiv : StEmit;
      end
      StDiv:   if (dstep_q == 5'd1) state_d = StEmit;
      StEmit:  if (!ov_q) state_d = StRead;
      default: state_d = StIdle;
    endcase
  end

  // Result register flag: set on emit, cleared by a result transfer.
  always_comb begin
    ov_d = ov_q;
    if (ov_q && pop) ov_d = 1'b0;
    if (state_q == StEmit && !ov_q) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      head_q  <= '0;
      last_q  <= 1'b0;
      ov_q    <= 1'b0;
      tap_q   <= '0;
      dstep_q <= '0;
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      case (state_q)
        StIdle: begin
          if (ram_we) begin
            fill_q <= fill_q + 1'b1;
            last_q <= cmd_i.last;
          end
        end
        StRead: begin
          dec_q <= dec_go && (len > FillW'(1));
          // A finished sequence restarts the window at entry zero.
          if (!dec_go && !drain_go && last_q) begin
            head_q <= '0;
            last_q <= 1'b0;
          end
        end
        StAcc: begin
          if (dec_q && !tap_last) tap_q <= tap_q + 1'b1;
          if (dec_q && tap_last) dstep_q <= 5'(DivSteps + 1);
        end
        StDiv: dstep_q <= dstep_q - 1'b1;
        StEmit: begin
          if (!ov_q) begin
            head_q <= head_q + 1'b1;
            fill_q <= fill_q - 1'b1;
            tap_q  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // One restoring division step per lane.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      trial[j] = {rem_q[j][4:0], num_q[j][DivW-1]};
      fit[j]   = (trial[j] >= len_ext);
    end
  end

  // Final lane values: signed quotient wrapped to 16 bits, or the raw sample.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (!dec_q) res_val[j] = raw_q[j];
      else if (sgn_q[j]) res_val[j] = 16'(-num_q[j]);
      else res_val[j] = num_q[j][15:0];
    end
  end

  // Datapath: accumulate over the code taps, then divide the magnitude.
  always_ff @(posedge clk_i) begin
    if (state_q == StRead) begin
      for (int j = 0; j < 4; j++) acc_q[j] <= '0;
    end
    if (state_q == StAcc) begin
      for (int j = 0; j < 4; j++) begin
        if (tap_q == '0) raw_q[j] <= rdata[16*j +: 16];
        if (plus) acc_q[j] <= acc_q[j] + 21'(signed'(rdata[16*j +: 16]));
        else      acc_q[j] <= acc_q[j] - 21'(signed'(rdata[16*j +: 16]));
      end
    end
    if (state_q == StDiv) begin
      for (int j = 0; j < 4; j++) begin
        if (dstep_q == 5'(DivSteps + 1)) begin
          sgn_q[j] <= acc_q[j][20];
          num_q[j] <= DivW'(acc_q[j][20] ? -acc_q[j] : acc_q[j]);
          rem_q[j] <= '0;
        end else if (fit[j]) begin
          rem_q[j] <= trial[j] - len_ext;
          num_q[j] <= {num_q[j][DivW-2:0], 1'b1};
        end else begin
          rem_q[j] <= trial[j];
          num_q[j] <= {num_q[j][DivW-2:0], 1'b0};
        end
      end
    end
    if (state_q == StEmit && !ov_q) begin
      res_q <= '{last_out:   last_q && (fill_q == FillW'(1)),
                 is_decoded: dec_q,
                 out_back_q: res_val[3],
                 out_back_i: res_val[2],
                 out_main_q: res_val[1],
                 out_main_i: res_val[0]};
    end
  end
endmodule

// ===== hdl/iq_phase_code_decoder_unit.sv =====
`timescale 1ns / 1ps
// Binary phase code pulse compressor for paired main / back I/Q samples.
// Input: push with full; an item transfers at a clock edge with push high
// and full low. Results: empty with pop; the oldest result sits on res_o
// while empty is low and transfers at an edge with pop high.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// register 0 is the code length, register 1 the code sign bits. cfg_ready_o
// is high only while no item is queued or being worked on.
// A two-entry queue parts the front (main inversion) from the back
// sequencer, which keeps a 16-entry window RAM, walks one code tap per
// cycle and runs a 20-step restoring divide by the length L.
// The back part takes a new sample from the queue only after it has
// emitted every result that its last sample caused; a decoded result
// passes the accumulate and divide states, a raw one skips the divide.
// Reset empties the window, the queue and the result flag; code length
// returns to 1 and the code signs to all ones.
// When the receiver stalls, the result holds, the back part waits to emit
// and the front queue takes items until full is raised.
module iq_phase_code_decoder_unit import ipcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  logic [4:0]  code_length_q;
  logic [15:0] code_signs_q;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;

  // Writes are taken only while the queue is empty and the back part idles.
  assign cfg_ready_o = cmd_ready && !cmd_valid;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_length_q <= 5'd1;
      code_signs_q  <= 16'hFFFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegCodeLength: code_length_q <= cfg_data_i[4:0];
        RegCodeSigns:  code_signs_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ipcd_front u_front (
    .clk_i, .rst_ni, .push, .full, .item_i,
    .cmd_valid_o (cmd_valid), .cmd_ready_i (cmd_ready), .cmd_o (cmd)
  );

  ipcd_back u_back (
    .clk_i, .rst_ni,
    .code_length_i (code_length_q), .code_signs_i (code_signs_q),
    .cmd_valid_i (cmd_valid), .cmd_ready_o (cmd_ready), .cmd_i (cmd),
    .empty, .pop, .res_o
  );
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import ipcd_pkg::*;

  // Scoreboard: holds the window model and the queue of expected results.
  class decode_scoreboard;
    logic [63:0] window [MaxBaud];
    int unsigned fill;
    int unsigned head;
    logic [4:0]  code_len;
    logic [15:0] code_sign_bits;
    out_item_t   pending[$];
    int          errors;

    function void reset_state();
      fill = 0;
      head = 0;
      code_len = 5'd1;
      code_sign_bits = 16'hFFFF;
      pending.delete();
      errors = 0;
    endfunction

    function logic [63:0] held(int unsigned i);
      return window[(head + i) % MaxBaud];
    endfunction

    function logic [63:0] correlate(int unsigned len);
      int          acc [4];
      int          v;
      int          q;
      logic [63:0] r;
      logic [63:0] e;
      r = '0;
      for (int j = 0; j < 4; j++) acc[j] = 0;
      for (int unsigned i = 0; i < len; i++) begin
        e = held(i);
        for (int j = 0; j < 4; j++) begin
          v = $signed(e[16*j +: 16]);
          acc[j] += code_sign_bits[i] ? v : -v;
        end
      end
      for (int j = 0; j < 4; j++) begin
        q = acc[j] / int'(len);
        r[16*j +: 16] = q[15:0];
      end
      return r;
    endfunction

    function void emit(logic [63:0] s, logic dec);
      out_item_t o;
      o.out_main_i = s[15:0];
      o.out_main_q = s[31:16];
      o.out_back_i = s[47:32];
      o.out_back_q = s[63:48];
      o.is_decoded = dec;
      o.last_out   = 1'b0;
      pending.push_back(o);
    endfunction

    // Note one accepted input item and predict the results it causes.
    function void note_input(in_item_t it);
      int unsigned len;
      int unsigned n;
      logic [63:0] s;
      n = 0;
      len = code_len;
      if (len < 1) len = 1;
      if (len > MaxBaud) len = MaxBaud;
      s = {it.back_q, it.back_i, 16'(-it.main_q), 16'(-it.main_i)};
      if (fill >= MaxBaud) fill = MaxBaud - 1;
      window[(head + fill) % MaxBaud] = s;
      fill++;
      while (fill >= len) begin
        if (len > 1) emit(correlate(len), 1'b1);
        else emit(held(0), 1'b0);
        n++;
        head = (head + 1) % MaxBaud;
        fill--;
      end
      if (it.last_in) begin
        while (fill > 0) begin
          emit(held(0), 1'b0);
          n++;
          head = (head + 1) % MaxBaud;
          fill--;
        end
        head = 0;
        if (n > 0) pending[$].last_out = 1'b1;
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp_item = pending.pop_front();
      if (got.out_main_i !== exp_item.out_main_i) begin
        $error("out_main_i exp %h got %h", exp_item.out_main_i, got.out_main_i);
        errors++;
      end
      if (got.out_main_q !== exp_item.out_main_q) begin
        $error("out_main_q exp %h got %h", exp_item.out_main_q, got.out_main_q);
        errors++;
      end
      if (got.out_back_i !== exp_item.out_back_i) begin
        $error("out_back_i exp %h got %h", exp_item.out_back_i, got.out_back_i);
        errors++;
      end
      if (got.out_back_q !== exp_item.out_back_q) begin
        $error("out_back_q exp %h got %h", exp_item.out_back_q, got.out_back_q);
        errors++;
      end
      if (got.is_decoded !== exp_item.is_decoded) begin
        $error("is_decoded exp %b got %b", exp_item.is_decoded, got.is_decoded);
        errors++;
      end
      if (got.last_out !== exp_item.last_out) begin
        $error("last_out exp %b got %b", exp_item.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  in_item_t    item_i;
  logic        empty;
  logic        pop;
  out_item_t   res_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  decode_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_start;
  bit  recv_hold;
  longint cycle_count;

  localparam longint CycleLimit = 2000000;

  iq_phase_code_decoder_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .item_i(item_i),
    .empty(empty), .pop(pop), .res_o(res_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Cycle counter with a timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("iq_phase_code_decoder_unit regression: fail");
      $finish;
    end
  end

  // Long receiver hold, counted in cycles, while the sender keeps going.
  initial begin
    recv_hold = 1'b0;
    wait (hold_start);
    recv_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  // Receiver: pops with random stalls and checks each result transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_result(res_o);
      if (recv_hold) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Write one configuration register while the block is idle.
  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegCodeLength) sb.code_len = val[4:0];
    else sb.code_sign_bits = val;
  endtask

  // Offer one item until it transfers, with random idle cycles before it.
  // Push stays high after the transfer; the next item or drain() sets it.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    sb.note_input(it);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_item(bit last);
    in_item_t it;
    it.main_i = 16'($urandom);
    it.main_q = 16'($urandom);
    it.back_i = 16'($urandom);
    it.back_q = 16'($urandom);
    if ($urandom_range(7) == 0) begin
      it.main_i = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      it.back_q = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    end
    it.last_in = last;
    return it;
  endfunction

  function automatic in_item_t const_item(logic [15:0] v, bit last);
    in_item_t it;
    it.main_i = v;
    it.main_q = v;
    it.back_i = v;
    it.back_q = v;
    it.last_in = last;
    return it;
  endfunction

  // Send one pulse sequence of n items closed by a last marker.
  task automatic send_sequence(int n);
    for (int k = 0; k < n; k++) send_item(rand_item(k == n - 1));
  endtask

  initial begin
    int lens [6] = '{1, 2, 16, 0, 31, 5};
    int phase;
    sb = new();
    sb.reset_state();
    cycle_count = 0;
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegCodeLength;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_start = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset setting passes straight through, then extremes.
    send_item(const_item(16'h8000, 1'b0));
    send_item(const_item(16'h7FFF, 1'b0));
    send_item(const_item(16'h0000, 1'b1));
    drain();
    // All 16 bauds at the most negative value with code +1, then such items with code -1.
    write_reg(RegCodeLength, 16'd16);
    write_reg(RegCodeSigns, 16'hFFFF);
    for (int k = 0; k < 16; k++) send_item(const_item(16'h8000, k == 15));
    drain();
    write_reg(RegCodeSigns, 16'h0000);
    for (int k = 0; k < 3; k++) send_item(const_item(16'h8000, 1'b0));
    // Length change in the middle of a sequence.
    drain();
    write_reg(RegCodeLength, 16'd2);
    send_item(const_item(16'h1234, 1'b0));
    drain();
    write_reg(RegCodeLength, 16'd1);
    send_item(const_item(16'h7FFF, 1'b1));
    drain();

    // Random phases over several settings and idling patterns.
    for (phase = 0; phase < 8; phase++) begin
      write_reg(RegCodeLength, 16'(lens[phase % 6]));
      write_reg(RegCodeSigns, 16'($urandom));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      if (phase == 2) begin
        hold_start = 1'b1;
        send_sequence(20);
      end
      for (int s = 0; s < 3; s++) begin
        if ($urandom_range(4) == 0) send_item(rand_item($urandom_range(1)));
        else send_sequence($urandom_range(1, 20));
      end
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("iq_phase_code_decoder_unit regression: pass");
    end else begin
      $display("iq_phase_code_decoder_unit regression: fail");
    end
    $finish;
  end
endmodule
